/* rtl/snsim_pkg.sv */
// ----------------------------------------------------------------------------
// snsim_pkg
// Shared types and constants of the shared-neighbor similarity core:
// opcodes, register indexes, field widths, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package snsim_pkg;

	// Field widths of the external beats
	localparam int OP_W    = 1;
	localparam int ROW_W   = 10;
	localparam int SLOT_W  = 5;
	localparam int NID_W   = 11;
	localparam int CNT_W   = 11;
	localparam int SIM_W   = 17;
	localparam int K_W     = 6;
	localparam int TK_W    = K_W + 1;
	localparam int CIDX_W  = 1;
	localparam int CDATA_W = 17;

	// Fraction bits of the similarity and the divider step count
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = FRAC_W;
	// Cycles from the last row read until the shared count is settled
	localparam int DRAIN_CYC = 2;

	localparam logic [SIM_W-1:0] SIM_ONE   = SIM_W'(1) << FRAC_W;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [K_W-1:0]   K_RESET   = K_W'(32);
	localparam logic [SIM_W-1:0] THR_RESET = '0;

	// Opcodes
	localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	// Register indexes
	localparam logic [CIDX_W-1:0] CFG_NEIGHBORS_USED  = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_PRUNE_THRESHOLD = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_B,
		ST_RD_A,
		ST_DRAIN,
		ST_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic           load_wr;   // store one neighbor entry from the input beat
		logic           capture;   // latch the query rows, clear the count
		logic           rd_en;     // read one store entry
		logic           rd_b;      // read belongs to the second row
		logic [K_W-1:0] slot;      // slot being read
		logic           div_init;  // classify the count and seed the divider
		logic           div_step;  // one quotient bit
		logic           out_load;  // move the result into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;            // output register can take a result now
	} status_t;

endpackage

`default_nettype wire

/* rtl/snsim_ctrl.sv */
// ----------------------------------------------------------------------------
// snsim_ctrl
// Query sequencer: steps through the reads of both rows, waits for the
// match count to settle, runs the divider and hands the result to the
// output register. Loads complete in the accept cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module snsim_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [snsim_pkg::OP_W-1:0]    opcode,
	input  wire logic [snsim_pkg::K_W-1:0]     k,
	input  wire snsim_pkg::status_t            status,
	output snsim_pkg::cmd_t                    cmd
);

	snsim_pkg::state_t              state_q, state_d;
	logic [snsim_pkg::K_W-1:0]      cnt_q, cnt_d;
	logic                           last_slot;
	logic                           in_beat;

	assign last_slot = ((cnt_q + snsim_pkg::K_W'(1)) == k);
	assign in_beat   = in_valid && in_ready;

	// Hold state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= snsim_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			snsim_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_valid && opcode == snsim_pkg::OP_QUERY) begin
					state_d = (k == '0) ? snsim_pkg::ST_DRAIN : snsim_pkg::ST_RD_B;
				end
			end
			snsim_pkg::ST_RD_B: begin
				if (last_slot) begin
					state_d = snsim_pkg::ST_RD_A;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + snsim_pkg::K_W'(1);
				end
			end
			snsim_pkg::ST_RD_A: begin
				if (last_slot) begin
					state_d = snsim_pkg::ST_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + snsim_pkg::K_W'(1);
				end
			end
			snsim_pkg::ST_DRAIN: begin
				if (cnt_q == snsim_pkg::K_W'(snsim_pkg::DRAIN_CYC - 1)) begin
					state_d = snsim_pkg::ST_INIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + snsim_pkg::K_W'(1);
				end
			end
			snsim_pkg::ST_INIT: begin
				state_d = snsim_pkg::ST_DIV;
				cnt_d   = '0;
			end
			snsim_pkg::ST_DIV: begin
				if (cnt_q == snsim_pkg::K_W'(snsim_pkg::DIV_STEPS - 1)) begin
					state_d = snsim_pkg::ST_DONE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + snsim_pkg::K_W'(1);
				end
			end
			snsim_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = snsim_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = snsim_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// Commands
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.slot     = cnt_q;
		case (state_q)
			snsim_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_wr = in_beat && opcode == snsim_pkg::OP_LOAD;
				cmd.capture = in_beat && opcode == snsim_pkg::OP_QUERY;
			end
			snsim_pkg::ST_RD_B: begin
				cmd.rd_en = 1'b1;
				cmd.rd_b  = 1'b1;
			end
			snsim_pkg::ST_RD_A: begin
				cmd.rd_en = 1'b1;
			end
			snsim_pkg::ST_INIT: begin
				cmd.div_init = 1'b1;
			end
			snsim_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			snsim_pkg::ST_DONE: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/snsim_dp.sv */
// ----------------------------------------------------------------------------
// snsim_dp
// Datapath: neighbor store, a row of cells that holds the second row,
// compare and count stages, a one-bit-per-cycle divider and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module snsim_dp #(
	parameter int MAX_POINTS    = 1024,
	parameter int MAX_NEIGHBORS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire snsim_pkg::cmd_t                  cmd,
	output snsim_pkg::status_t                    status,
	input  wire logic [snsim_pkg::ROW_W-1:0]      row_index,
	input  wire logic [snsim_pkg::SLOT_W-1:0]     slot_index,
	input  wire logic [snsim_pkg::NID_W-1:0]      neighbor_id,
	input  wire logic [snsim_pkg::ROW_W-1:0]      other_row,
	input  wire logic [snsim_pkg::K_W-1:0]        k,
	input  wire logic [snsim_pkg::SIM_W-1:0]      prune,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [snsim_pkg::ROW_W-1:0]           result_row,
	output logic [snsim_pkg::ROW_W-1:0]           result_col,
	output logic [snsim_pkg::CNT_W-1:0]           shared_count,
	output logic [snsim_pkg::SIM_W-1:0]           similarity,
	output logic                                  present
);

	localparam int DEPTH = MAX_POINTS * MAX_NEIGHBORS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(MAX_POINTS);
	localparam int SL_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int KMAX  = (MAX_NEIGHBORS < 63) ? MAX_NEIGHBORS : 63;
	localparam int SH_W  = $clog2(KMAX * KMAX + 1);
	localparam int PC_W  = $clog2(MAX_NEIGHBORS + 1);
	localparam int CW    = ((SH_W > snsim_pkg::TK_W) ? SH_W : snsim_pkg::TK_W) + 1;
	localparam int TK_W  = snsim_pkg::TK_W;

	// Neighbor store
	logic [NW-1:0]    mem [DEPTH];
	logic [AW-1:0]    waddr, raddr;
	logic             wr_ok;
	logic [NW-1:0]    wdata;

	// Query rows
	logic [snsim_pkg::ROW_W-1:0] row_a_q, row_b_q;
	logic                        bad_q;
	logic [snsim_pkg::ROW_W-1:0] rd_row;

	// Read, compare and count stages
	logic                        rd_vld_s1, rd_b_s1;
	logic [SL_W-1:0]             slot_s1;
	logic [NW-1:0]               rdata_s1;
	logic [NW-1:0]               cells_q [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0]    match_d, match_s2;
	logic                        match_vld_s2;
	logic [PC_W-1:0]             pc;
	logic [SH_W-1:0]             acc_q;

	// Divider
	logic [CW-1:0]               sh_w, tk_w;
	logic                        zero_q, sat_q;
	logic [TK_W-1:0]             rem_q, den_q;
	logic [TK_W:0]               rem2;
	logic [snsim_pkg::FRAC_W-1:0] quot_q;
	logic [snsim_pkg::SIM_W-1:0] sim;
	logic                        keep;

	// Load address, data and range check
	assign waddr = AW'(32'(row_index) * MAX_NEIGHBORS + 32'(slot_index));
	assign wdata = NW'(neighbor_id - snsim_pkg::NID_W'(1));
	assign wr_ok = (32'(row_index) < MAX_POINTS) && (32'(slot_index) < MAX_NEIGHBORS)
		&& (neighbor_id != '0) && (32'(neighbor_id) <= MAX_POINTS);

	assign rd_row = cmd.rd_b ? row_b_q : row_a_q;
	assign raddr  = AW'(32'(rd_row) * MAX_NEIGHBORS + 32'(cmd.slot));

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en && !bad_q) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Latch query rows; flag rows outside the store
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_a_q <= row_index;
			row_b_q <= other_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q        <= 1'b0;
			rd_vld_s1    <= 1'b0;
			match_vld_s2 <= 1'b0;
		end else begin
			if (cmd.capture) begin
				bad_q <= (32'(row_index) >= MAX_POINTS) || (32'(other_row) >= MAX_POINTS);
			end
			rd_vld_s1    <= cmd.rd_en && !bad_q;
			match_vld_s2 <= rd_vld_s1 && !rd_b_s1;
		end
	end

	// Carry read tags alongside the store output
	always_ff @(posedge clk) begin
		rd_b_s1 <= cmd.rd_b;
		slot_s1 <= SL_W'(cmd.slot);
	end

	// Fill the cell row with the second row's neighbors
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_b_s1) begin
			cells_q[slot_s1] <= rdata_s1;
		end
	end

	// Compare one first-row neighbor against every active cell
	always_comb begin
		for (int t = 0; t < MAX_NEIGHBORS; t++) begin
			match_d[t] = (cells_q[t] == rdata_s1) && (32'(t) < 32'(k));
		end
	end

	always_ff @(posedge clk) begin
		match_s2 <= match_d;
	end

	// Count matches of one compare beat
	always_comb begin
		pc = '0;
		for (int t = 0; t < MAX_NEIGHBORS; t++) begin
			pc = pc + PC_W'(match_s2[t]);
		end
	end

	// Accumulate the shared count
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (match_vld_s2) begin
			acc_q <= acc_q + SH_W'(pc);
		end
	end

	// Classify the count and run the divider, one quotient bit a cycle
	assign sh_w = CW'(acc_q);
	assign tk_w = CW'({k, 1'b0});
	assign rem2 = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			zero_q <= (sh_w == '0) || (sh_w > tk_w);
			sat_q  <= (sh_w << 1) >= tk_w;
			rem_q  <= TK_W'(sh_w);
			den_q  <= TK_W'(tk_w - sh_w);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (rem2 >= {1'b0, den_q}) begin
				rem_q  <= TK_W'(rem2 - {1'b0, den_q});
				quot_q <= {quot_q[snsim_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				rem_q  <= TK_W'(rem2);
				quot_q <= {quot_q[snsim_pkg::FRAC_W-2:0], 1'b0};
			end
		end
	end

	// Saturate, then prune
	assign sim  = zero_q ? '0 : (sat_q ? snsim_pkg::SIM_ONE : {1'b0, quot_q});
	assign keep = (sim != '0) && (sim >= prune);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_row   <= row_a_q;
			result_col   <= row_b_q;
			shared_count <= (32'(acc_q) > 32'(snsim_pkg::CNT_MAX)) ? snsim_pkg::CNT_MAX
				: snsim_pkg::CNT_W'(acc_q);
			similarity   <= keep ? sim : '0;
			present      <= keep;
		end
	end

	assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

/* rtl/shared_neighbor_similarity_core.sv */
// ----------------------------------------------------------------------------
// shared_neighbor_similarity_core
// Shared-nearest-neighbor similarity: loads neighbor lists into a store,
// counts equal neighbor pairs between two rows and reports
// shared / (2k - shared) in Q1.16 with pruning.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | in_valid / in_ready    | opcode, row_index, slot_index,
//           |           |                        | neighbor_id, other_row
//   out     | source    | out_valid / out_ready  | result_row, result_col,
//           |           |                        | shared_count, similarity, present
//   cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load is written in its accept cycle. A query reads k entries of each
// row through the store's single read port, then runs the compare and
// count stages and a 16-step restoring divider into the output register.
// The next item is taken once the query reaches the output register; a
// result waiting there holds only the hand-off of the following query.
// Reset clears control state and restores k = 32, threshold 0; the store
// holds no reset value. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_neighbor_similarity_core #(
	parameter int MAX_POINTS    = 1024,
	parameter int MAX_NEIGHBORS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [snsim_pkg::OP_W-1:0]         opcode,
	input  wire logic [snsim_pkg::ROW_W-1:0]        row_index,
	input  wire logic [snsim_pkg::SLOT_W-1:0]       slot_index,
	input  wire logic [snsim_pkg::NID_W-1:0]        neighbor_id,
	input  wire logic [snsim_pkg::ROW_W-1:0]        other_row,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [snsim_pkg::ROW_W-1:0]             result_row,
	output logic [snsim_pkg::ROW_W-1:0]             result_col,
	output logic [snsim_pkg::CNT_W-1:0]             shared_count,
	output logic [snsim_pkg::SIM_W-1:0]             similarity,
	output logic                                    present,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [snsim_pkg::CIDX_W-1:0]       cfg_index,
	input  wire logic [snsim_pkg::CDATA_W-1:0]      cfg_data
);

	logic [snsim_pkg::K_W-1:0]   nbr_used_q;
	logic [snsim_pkg::SIM_W-1:0] prune_q;
	logic [snsim_pkg::K_W-1:0]   k_eff;
	snsim_pkg::cmd_t             cmd;
	snsim_pkg::status_t          status;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbr_used_q <= snsim_pkg::K_RESET;
			prune_q    <= snsim_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				snsim_pkg::CFG_NEIGHBORS_USED:  nbr_used_q <= cfg_data[snsim_pkg::K_W-1:0];
				snsim_pkg::CFG_PRUNE_THRESHOLD: prune_q    <= cfg_data[snsim_pkg::SIM_W-1:0];
				default: begin
					prune_q <= prune_q;
				end
			endcase
		end
	end

	// Clip k to the slots the store holds
	assign k_eff = (32'(nbr_used_q) > MAX_NEIGHBORS) ? snsim_pkg::K_W'(MAX_NEIGHBORS)
		: nbr_used_q;

	snsim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.k        (k_eff),
		.status   (status),
		.cmd      (cmd)
	);

	snsim_dp #(
		.MAX_POINTS    (MAX_POINTS),
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.row_index    (row_index),
		.slot_index   (slot_index),
		.neighbor_id  (neighbor_id),
		.other_row    (other_row),
		.k            (k_eff),
		.prune        (prune_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_row   (result_row),
		.result_col   (result_col),
		.shared_count (shared_count),
		.similarity   (similarity),
		.present      (present)
	);

	// A query beat closes the input until its result is handed off
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == snsim_pkg::OP_QUERY) |=> !in_ready)
		else $error("input taken while a query is in progress");

	// A pruned result carries zero similarity
	a_pruned_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !present) |-> (similarity == '0))
		else $error("pruned result with nonzero similarity");

	// A kept edge has matches and meets the threshold
	a_kept_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && present) |-> (shared_count != '0 && similarity >= prune_q
			&& similarity != '0))
		else $error("kept edge without matches or below threshold");

	// A result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.out_load)
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

/* test/tb_shared_neighbor_similarity_core.sv */
// ----------------------------------------------------------------------------
// tb_shared_neighbor_similarity_core
// Self-checking bench for the shared-neighbor similarity core. A bench-side
// copy of the neighbor table and registers predicts every query result.
// Results are compared field by field against the oldest prediction.
// The run fills a pool of rows first. A directed pass follows over the
// extremes, bad loads and the saturating, zero and pruned similarity cases.
// Random traffic then runs under several register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_shared_neighbor_similarity_core;
	timeunit 1ns;
	timeprecision 1ps;

	import snsim_pkg::*;

	localparam int NUM_ROWS   = 1024;
	localparam int NUM_SLOTS  = 32;
	localparam int POOL_N     = 8;
	// longest query latency plus margin
	localparam int SETTLE_CYC = 2 * NUM_SLOTS + 21 + 16;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [ROW_W-1:0]  row;
		logic [SLOT_W-1:0] slot;
		logic [NID_W-1:0]  nid;
		logic [ROW_W-1:0]  other;
	} item_t;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [CNT_W-1:0] shared;
		logic [SIM_W-1:0] sim;
		logic             present;
	} edge_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode      = '0;
	logic [ROW_W-1:0]    row_index   = '0;
	logic [SLOT_W-1:0]   slot_index  = '0;
	logic [NID_W-1:0]    neighbor_id = '0;
	logic [ROW_W-1:0]    other_row   = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [ROW_W-1:0]    result_row;
	logic [ROW_W-1:0]    result_col;
	logic [CNT_W-1:0]    shared_count;
	logic [SIM_W-1:0]    similarity;
	logic                present;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index   = '0;
	logic [CDATA_W-1:0]  cfg_data    = '0;

	// Bench copy of the neighbor table and registers
	logic [ROW_W-1:0] nbr_table [NUM_ROWS][NUM_SLOTS];
	logic [K_W-1:0]   k_reg   = K_RESET;
	logic [SIM_W-1:0] thr_reg = THR_RESET;
	edge_t            edge_queue [$];
	int               errors    = 0;
	bit               fast_mode = 1'b0;

	// Rows fully loaded before any query; only these are ever queried
	logic [ROW_W-1:0] pool_rows [POOL_N] = '{10'd0, 10'd1023, 10'd2, 10'd3,
		10'd341, 10'd682, 10'd512, 10'd5};

	shared_neighbor_similarity_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.row_index    (row_index),
		.slot_index   (slot_index),
		.neighbor_id  (neighbor_id),
		.other_row    (other_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_row   (result_row),
		.result_col   (result_col),
		.shared_count (shared_count),
		.similarity   (similarity),
		.present      (present),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count matching slot pairs and form the pruned Q1.16 similarity
	function automatic edge_t predict_edge(logic [ROW_W-1:0] ra, logic [ROW_W-1:0] rb);
		int unsigned     k;
		int unsigned     n;
		int unsigned     twok;
		longint unsigned q;
		edge_t           e;
		k = (k_reg > NUM_SLOTS) ? NUM_SLOTS : k_reg;
		n = 0;
		for (int s = 0; s < k; s++)
			for (int t = 0; t < k; t++)
				if (nbr_table[rb][t] == nbr_table[ra][s])
					n++;
		twok = 2 * k;
		if (n == 0 || n > twok) begin
			q = 0;
		end else if (n == twok) begin
			q = SIM_ONE;
		end else begin
			q = (64'(n) << FRAC_W) / (twok - n);
			if (q > SIM_ONE)
				q = SIM_ONE;
		end
		e.present = (q != 0) && (q >= thr_reg);
		e.row     = ra;
		e.col     = rb;
		e.shared  = (n > CNT_MAX) ? CNT_MAX : CNT_W'(n);
		e.sim     = e.present ? SIM_W'(q) : '0;
		return e;
	endfunction

	function automatic item_t load_item(int row, int slot, int nid);
		item_t it;
		it.op    = OP_LOAD;
		it.row   = ROW_W'(row);
		it.slot  = SLOT_W'(slot);
		it.nid   = NID_W'(nid);
		it.other = ROW_W'($urandom);
		return it;
	endfunction

	function automatic item_t query_item(logic [ROW_W-1:0] ra, logic [ROW_W-1:0] rb);
		item_t it;
		it.op    = OP_QUERY;
		it.row   = ra;
		it.slot  = SLOT_W'($urandom);
		it.nid   = NID_W'($urandom);
		it.other = rb;
		return it;
	endfunction

	// k register word with junk in the unused upper bits
	function automatic logic [CDATA_W-1:0] k_word(int k);
		logic [CDATA_W-1:0] w;
		w = CDATA_W'($urandom);
		w[K_W-1:0] = K_W'(k);
		return w;
	endfunction

	// Drive one input beat, then fold it into the bench model once accepted
	task automatic send_item(input item_t it);
		int gap;
		gap = fast_mode ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= it.op;
		row_index   <= it.row;
		slot_index  <= it.slot;
		neighbor_id <= it.nid;
		other_row   <= it.other;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		if (it.op == OP_LOAD) begin
			// drop loads with an out-of-range neighbor id
			if (it.nid >= 1 && it.nid <= NUM_ROWS)
				nbr_table[it.row][it.slot] = ROW_W'(it.nid - 1);
		end else begin
			edge_queue.insert(edge_queue.size(), predict_edge(it.row, it.other));
		end
	endtask

	// Hold off until every expected result is out and the core is idle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (edge_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		if (idx == CFG_NEIGHBORS_USED)
			k_reg = data[K_W-1:0];
		else
			thr_reg = data;
	endtask

	// Write both registers back to back while the core is idle
	task automatic configure(input logic [CDATA_W-1:0] k_data,
			input logic [CDATA_W-1:0] thr_data);
		quiesce();
		cfg_beat(CFG_NEIGHBORS_USED, k_data);
		cfg_beat(CFG_PRUNE_THRESHOLD, thr_data);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Load every slot of the pool rows; row 0 all ones, row 1023 all top ids
	task automatic test_fill_pool();
		int nid;
		for (int r = 0; r < POOL_N; r++) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (pool_rows[r] == 0)
					nid = 1;
				else if (pool_rows[r] == NUM_ROWS - 1)
					nid = NUM_ROWS;
				else
					nid = $urandom_range(1, 32);
				send_item(load_item(pool_rows[r], s, nid));
			end
		end
	endtask

	// Reset settings: full-duplicate rows and disjoint rows
	task automatic test_extremes();
		send_item(query_item(10'd0, 10'd0));
		send_item(query_item(10'd1023, 10'd1023));
		send_item(query_item(10'd0, 10'd1023));
		send_item(query_item(10'd1023, 10'd0));
		send_item(query_item(10'd2, 10'd341));
	endtask

	task automatic test_special_cases();
		// ratio above one: {1,1,2} against {1,1,7} at k = 3
		configure(k_word(3), '0);
		send_item(load_item(2, 0, 1));
		send_item(load_item(2, 1, 1));
		send_item(load_item(2, 2, 2));
		send_item(load_item(3, 0, 1));
		send_item(load_item(3, 1, 1));
		send_item(load_item(3, 2, 7));
		send_item(query_item(10'd2, 10'd3));
		// bad loads must leave row 2 untouched
		send_item(load_item(2, 2, 0));
		send_item(load_item(2, 2, NUM_ROWS + 1));
		send_item(load_item(1023, 31, 2047));
		send_item(query_item(10'd2, 10'd3));
		// ratio of exactly one
		configure(k_word(1), '0);
		send_item(query_item(10'd0, 10'd0));
		send_item(query_item(10'd2, 10'd3));
		// zero denominator
		configure(k_word(2), '0);
		send_item(query_item(10'd0, 10'd0));
		send_item(query_item(10'd2, 10'd3));
		// zero k
		configure(k_word(0), '0);
		send_item(query_item(10'd2, 10'd3));
		// threshold at one: only saturated edges survive
		configure(k_word(3), SIM_ONE);
		send_item(query_item(10'd2, 10'd3));
		send_item(query_item(10'd2, 10'd341));
		// k above the slot count acts as the slot count
		configure(k_word(63), 17'd1);
		send_item(query_item(10'd0, 10'd1023));
		send_item(query_item(10'd2, 10'd682));
	endtask

	// Mix of pool queries, pool reloads, stray loads and bad loads
	task automatic test_random_traffic(input int n_items, input int span);
		int    pick;
		item_t it;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				it = query_item(pool_rows[$urandom_range(0, POOL_N - 1)],
					pool_rows[$urandom_range(0, POOL_N - 1)]);
			else if (pick < 80)
				it = load_item(pool_rows[$urandom_range(0, POOL_N - 1)],
					$urandom_range(0, NUM_SLOTS - 1), $urandom_range(1, span));
			else if (pick < 90)
				it = load_item($urandom_range(0, NUM_ROWS - 1),
					$urandom_range(0, NUM_SLOTS - 1), $urandom_range(1, NUM_ROWS));
			else
				it = load_item($urandom_range(0, NUM_ROWS - 1),
					$urandom_range(0, NUM_SLOTS - 1),
					($urandom_range(0, 1) == 0) ? 0 : $urandom_range(NUM_ROWS + 1, 2047));
			send_item(it);
		end
	endtask

	// Accept result beats with random stalls and compare to predictions
	initial begin : result_monitor
		int    stall;
		edge_t exp_e;
		wait (arst_n === 1'b1);
		forever begin
			stall = fast_mode ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (edge_queue.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual row %0d col %0d",
					$time, result_row, result_col);
				errors++;
			end else begin
				exp_e = edge_queue.pop_front();
				check_field("result_row", exp_e.row, result_row);
				check_field("result_col", exp_e.col, result_col);
				check_field("shared_count", exp_e.shared, shared_count);
				check_field("similarity", exp_e.sim, similarity);
				check_field("present", exp_e.present, present);
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main_seq
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_pool();
		test_extremes();
		test_special_cases();

		configure(k_word(32), '0);
		test_random_traffic(90, 32);
		configure(k_word(63), 17'($urandom_range(0, 65536)));
		test_random_traffic(90, 64);
		configure(k_word(1), SIM_ONE);
		test_random_traffic(90, 4);
		configure(k_word($urandom_range(2, 16)), 17'($urandom_range(0, 40000)));
		fast_mode = 1'b1;
		test_random_traffic(90, 16);
		fast_mode = 1'b0;
		configure(k_word(0), 17'($urandom_range(0, 65536)));
		test_random_traffic(40, 8);
		configure(k_word($urandom_range(17, 31)), 17'($urandom_range(0, 65536)));
		test_random_traffic(90, 1024);

		quiesce();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
